// ===== design/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg: shared types and round functions
// Lane and state types, per-item control, substitution and linear layers.
// ----------------------------------------------------------------------------
`default_nettype none

package spr_pkg;

	localparam int MAX_ROUNDS   = 4;
	localparam int NUM_LANES    = 5;
	localparam int LANE_W       = 64;
	localparam int MATCH_COUNT  = 18;
	localparam int ROUND_W      = $clog2(MAX_ROUNDS + 1);
	localparam int CFG_ROUNDS_W = 3;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 3;
	localparam int LATENCY      = MAX_ROUNDS + 1;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_ROUNDS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_SBOX  = CFG_IDX_W'(1);

	localparam int MATCH_POS [MATCH_COUNT] = '{
		11, 14, 16, 18, 22, 27, 29, 34, 35, 36, 37, 38, 44, 45, 46, 48, 62, 63
	};

	typedef logic [LANE_W-1:0] lane_t;
	typedef lane_t [NUM_LANES-1:0] state_t;
	typedef logic [MATCH_COUNT-1:0] match_t;

	typedef struct packed {
		logic [ROUND_W-1:0] rounds_left;
		logic               fin;
	} ctrl_t;

	function automatic lane_t rotr(input lane_t x, input int n);
		lane_t r;
		r = (x >> n) | (x << (LANE_W - n));
		return r;
	endfunction

	function automatic state_t sub_layer(input state_t s);
		state_t o;
		o[0] = (s[4] & s[1]) ^ s[3] ^ (s[2] & s[1]) ^ s[2] ^ (s[1] & s[0]) ^ s[1] ^ s[0];
		o[1] = s[4] ^ (s[3] & s[2]) ^ (s[3] & s[1]) ^ s[3] ^ (s[2] & s[1]) ^ s[2]
			^ s[1] ^ s[0];
		o[2] = ~((s[4] & s[3]) ^ s[4] ^ s[2] ^ s[1]);
		o[3] = (s[4] & s[0]) ^ s[4] ^ (s[3] & s[0]) ^ s[3] ^ s[2] ^ s[1] ^ s[0];
		o[4] = (s[4] & s[1]) ^ s[4] ^ s[3] ^ (s[1] & s[0]) ^ s[1];
		return o;
	endfunction

	function automatic state_t lin_layer(input state_t s);
		state_t o;
		o[0] = s[0] ^ rotr(s[0], 19) ^ rotr(s[0], 28);
		o[1] = s[1] ^ rotr(s[1], 61) ^ rotr(s[1], 39);
		o[2] = s[2] ^ rotr(s[2], 1)  ^ rotr(s[2], 6);
		o[3] = s[3] ^ rotr(s[3], 10) ^ rotr(s[3], 17);
		o[4] = s[4] ^ rotr(s[4], 7)  ^ rotr(s[4], 41);
		return o;
	endfunction

	function automatic match_t pick_match(input lane_t x);
		match_t m;
		for (int i = 0; i < MATCH_COUNT; i++) begin
			m[MATCH_COUNT-1-i] = x[LANE_W-1-MATCH_POS[i]];
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/spr_round_cell.sv =====
// ----------------------------------------------------------------------------
// spr_round_cell: one round slot of the chain
// Applies one full round when rounds remain, else passes the state on.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_round_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire spr_pkg::ctrl_t  in_ctrl,
	input  wire spr_pkg::state_t in_state,
	output logic                 out_valid,
	output spr_pkg::ctrl_t       out_ctrl,
	output spr_pkg::state_t      out_state
);

	logic            valid_q;
	spr_pkg::ctrl_t  ctrl_q;
	spr_pkg::state_t state_q;
	spr_pkg::ctrl_t  ctrl_d;
	spr_pkg::state_t state_d;
	logic            active;

	always_comb begin
		active = (in_ctrl.rounds_left != '0);
		ctrl_d = in_ctrl;
		state_d = in_state;
		if (active) begin
			ctrl_d.rounds_left = in_ctrl.rounds_left - 1'b1;
			state_d = spr_pkg::lin_layer(spr_pkg::sub_layer(in_state));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctrl_q  <= ctrl_d;
		state_q <= state_d;
	end

	assign out_valid = valid_q;
	assign out_ctrl  = ctrl_q;
	assign out_state = state_q;

endmodule

`default_nettype wire

// ===== design/spr_final_cell.sv =====
// ----------------------------------------------------------------------------
// spr_final_cell: tail of the chain
// Optional trailing substitution layer, match word, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spr_final_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire spr_pkg::ctrl_t  in_ctrl,
	input  wire spr_pkg::state_t in_state,
	output logic                 out_valid,
	output spr_pkg::state_t      out_state,
	output spr_pkg::match_t      out_match
);

	logic            valid_q;
	spr_pkg::state_t state_q;
	spr_pkg::match_t match_q;
	spr_pkg::state_t state_d;

	always_comb begin
		state_d = in_ctrl.fin ? spr_pkg::sub_layer(in_state) : in_state;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		state_q <= state_d;
		match_q <= spr_pkg::pick_match(state_d[0]);
	end

	assign out_valid = valid_q;
	assign out_state = state_q;
	assign out_match = match_q;

endmodule

`default_nettype wire

// ===== design/sponge_permutation_rounds.sv =====
// ----------------------------------------------------------------------------
// sponge_permutation_rounds: reduced-round sponge permutation
// Chain of round cells over a 320-bit state, one item per clock.
// ----------------------------------------------------------------------------
// Usage:
//   An item (lane_0..lane_4) is taken at a rising edge with start high and
//   busy low. busy stays low: a new item may enter every cycle.
//   Each item runs through MAX_ROUNDS round cells and one tail cell, one
//   cell per cycle; a cell with no rounds left passes the state unchanged.
//   The result (out_lane_0..out_lane_4, match_bits) shows for one cycle
//   with done high, from the result registers of the tail cell.
//   Throughput is one item per cycle, fixed by the cell chain depth only in
//   latency, not in rate.
//   full_rounds (index 0) and final_sbox (index 1) are written through
//   cfg_valid / cfg_ready / cfg_index / cfg_data; cfg_ready is always high.
//   Round settings are sampled when an item is taken and travel with it.
//   full_rounds above MAX_ROUNDS runs MAX_ROUNDS rounds.
//   Reset clears all items in flight and sets full_rounds 1, final_sbox 1.
//   The receiver cannot stall; done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module sponge_permutation_rounds (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [spr_pkg::LANE_W-1:0]        lane_0,
	input  wire logic [spr_pkg::LANE_W-1:0]        lane_1,
	input  wire logic [spr_pkg::LANE_W-1:0]        lane_2,
	input  wire logic [spr_pkg::LANE_W-1:0]        lane_3,
	input  wire logic [spr_pkg::LANE_W-1:0]        lane_4,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [spr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [spr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                   done,
	output logic [spr_pkg::LANE_W-1:0]             out_lane_0,
	output logic [spr_pkg::LANE_W-1:0]             out_lane_1,
	output logic [spr_pkg::LANE_W-1:0]             out_lane_2,
	output logic [spr_pkg::LANE_W-1:0]             out_lane_3,
	output logic [spr_pkg::LANE_W-1:0]             out_lane_4,
	output logic [spr_pkg::MATCH_COUNT-1:0]        match_bits
);

	localparam int RW = spr_pkg::ROUND_W;
	localparam int CW = spr_pkg::CFG_ROUNDS_W;
	localparam int NR = spr_pkg::MAX_ROUNDS;

	logic [CW-1:0]   full_rounds_q;
	logic            final_sbox_q;
	logic            accept;
	logic [RW-1:0]   rounds_sat;

	logic            chain_valid [NR+1];
	spr_pkg::ctrl_t  chain_ctrl  [NR+1];
	spr_pkg::state_t chain_state [NR+1];
	spr_pkg::state_t res_state;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_rounds_q <= CW'(1);
			final_sbox_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == spr_pkg::REG_FULL_ROUNDS) begin
				full_rounds_q <= cfg_data[CW-1:0];
			end else if (cfg_index == spr_pkg::REG_FINAL_SBOX) begin
				final_sbox_q <= cfg_data[0];
			end
		end
	end

	always_comb begin
		if (int'(full_rounds_q) > NR) begin
			rounds_sat = RW'(NR);
		end else begin
			rounds_sat = RW'(full_rounds_q);
		end
	end

	assign chain_valid[0]             = accept;
	assign chain_ctrl[0].rounds_left  = rounds_sat;
	assign chain_ctrl[0].fin          = final_sbox_q;
	assign chain_state[0][0]          = lane_0;
	assign chain_state[0][1]          = lane_1;
	assign chain_state[0][2]          = lane_2;
	assign chain_state[0][3]          = lane_3;
	assign chain_state[0][4]          = lane_4;

	for (genvar k = 0; k < NR; k++) begin : g_cell
		spr_round_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[k]),
			.in_ctrl   (chain_ctrl[k]),
			.in_state  (chain_state[k]),
			.out_valid (chain_valid[k+1]),
			.out_ctrl  (chain_ctrl[k+1]),
			.out_state (chain_state[k+1])
		);
	end

	spr_final_cell u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[NR]),
		.in_ctrl   (chain_ctrl[NR]),
		.in_state  (chain_state[NR]),
		.out_valid (done),
		.out_state (res_state),
		.out_match (match_bits)
	);

	assign out_lane_0 = res_state[0];
	assign out_lane_1 = res_state[1];
	assign out_lane_2 = res_state[2];
	assign out_lane_3 = res_state[3];
	assign out_lane_4 = res_state[4];

	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(spr_pkg::LATENCY) done)
		else $error("item taken without result after pipeline latency");

	a_done_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, spr_pkg::LATENCY))
		else $error("result strobe without matching item");

	a_rounds_capped: assert property (@(posedge clk) disable iff (!arst_n)
		chain_valid[1] |-> (int'(chain_ctrl[1].rounds_left) < NR))
		else $error("round count entered chain above limit");

endmodule

`default_nettype wire
